### hw/rtl/jgm_pkg.sv
`timescale 1ns / 1ps

package jgm_pkg;

    // joint count default and number of target fields carried by a goal request
    localparam int JOINTS_DEF    = 5;
    localparam int TARGET_FIELDS = 5;

    // register reset values
    localparam logic [30:0] THRESHOLD_RST = 31'd655;
    localparam logic [30:0] STALL_VEL_RST = 31'd0;
    localparam logic [31:0] TIMEOUT_RST   = 32'd100;
    localparam logic [31:0] GRACE_RST     = 32'd1000;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_GOAL   = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_STATE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_CMD    = 2'd0,
        KIND_FB     = 2'd1,
        KIND_STATUS = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_NONE      = 2'd0,
        ST_SUCCEEDED = 2'd1,
        ST_ABORTED   = 2'd2,
        ST_CANCELED  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_STALL_VEL = 2'd1,
        CFG_TIMEOUT   = 2'd2,
        CFG_GRACE     = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_GOAL_CANCEL,
        S_GOAL_CMD,
        S_STOP,
        S_CANCEL_ST,
        S_SAVE,
        S_ERR_ABS,
        S_ERR_CMP,
        S_ELAPSED,
        S_GRACE,
        S_DECIDE,
        S_VEL_LOAD,
        S_VEL_ABS,
        S_VEL_CMP,
        S_MOVE_ELAP,
        S_MOVE_CMP,
        S_FEEDBACK,
        S_STATUS
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        logic [2:0]         joint;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] target_0;
        logic signed [31:0] target_1;
        logic signed [31:0] target_2;
        logic signed [31:0] target_3;
        logic signed [31:0] target_4;
    } t_in;

    typedef struct packed {
        t_kind              kind;
        logic [2:0]         joint_out;
        logic signed [31:0] value;
        logic signed [31:0] pos_error;
        t_status            status;
        logic               stalled;
        logic               last;
    } t_out;

endpackage

### hw/rtl/joint_goal_monitor_core.sv
`timescale 1ns / 1ps

// channel   | signals                          | handshake
// ----------+----------------------------------+----------------------------------
// request   | i_req (t_in)                     | taken when start & !busy
// result    | o_res (t_out)                    | o_res_valid strobe, one cycle each
// config    | i_cfg_we, i_cfg_idx, i_cfg_data  | written on any edge with i_cfg_we
//
// one 34 bit subtractor is shared by all compares; each request runs to its end before the
// next is taken: a goal commands every joint (after a canceled status when one was active),
// a cancel stops the heard joints when a goal was given, a state update gives one feedback
// entry per joint unless dropped, with no active goal, or off target inside grace, plus a
// status result when the goal ends
// synchronous active-low reset clears control state and joint stores, presets config regs
// results are registered and leave at most one per cycle; the receiver cannot stall them

module joint_goal_monitor_core
    import jgm_pkg::*;
#(
    parameter int JOINTS = JOINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_req,
    output logic        o_res_valid,
    output t_out        o_res,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int IW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(JOINTS - 1);

    function automatic t_out make_out(t_kind k, logic [2:0] j, logic signed [31:0] v,
                                      logic signed [31:0] e, t_status s, logic stl,
                                      logic lst);
        t_out o;
        o.kind      = k;
        o.joint_out = j;
        o.value     = v;
        o.pos_error = e;
        o.status    = s;
        o.stalled   = stl;
        o.last      = lst;
        return o;
    endfunction

    // configuration registers
    logic [30:0] r_thr, r_svel;
    logic [31:0] r_timeout, r_grace;

    // goal state
    t_state             r_state, n_state;
    logic               r_active, n_active;
    logic               r_given, n_given;
    logic [31:0]        r_now, n_now;
    logic [31:0]        r_start, n_start;
    logic signed [31:0] r_tgt   [JOINTS];
    logic signed [31:0] r_pos   [JOINTS];
    logic [31:0]        r_mtime [JOINTS];
    logic [JOINTS-1:0]  r_heard, r_reached;

    // sequencer working registers
    t_in                r_req;
    logic [IW-1:0]      r_idx, n_idx;
    logic signed [33:0] r_tmp, n_tmp;
    logic               r_gt, n_gt, r_lt, n_lt;
    t_status            r_st, n_st;
    logic               r_stl, n_stl;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;

    // array write strobes, all at r_idx
    logic we_pos, we_goal, we_reach, we_move;

    // shared subtract unit
    logic signed [33:0] u_a, u_b, u_diff;
    logic               u_neg, u_pos;

    logic               accept;
    logic signed [31:0] tgt_sel, sat_err;
    logic [JOINTS-1:0]  reach_new, heard_above;

    assign u_diff = u_a - u_b;
    assign u_neg  = u_diff[33];
    assign u_pos  = !u_diff[33] && (u_diff != '0);

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // target of the current joint from the goal request, zero beyond the fields
    always_comb begin
        unique case (3'(r_idx))
            3'd0:    tgt_sel = r_req.target_0;
            3'd1:    tgt_sel = r_req.target_1;
            3'd2:    tgt_sel = r_req.target_2;
            3'd3:    tgt_sel = r_req.target_3;
            3'd4:    tgt_sel = r_req.target_4;
            default: tgt_sel = '0;
        endcase
    end

    // saturate the unit difference to 32 bits signed
    always_comb begin
        if (u_diff[33:31] == 3'b000 || u_diff[33:31] == 3'b111) begin
            sat_err = u_diff[31:0];
        end else if (u_diff[33]) begin
            sat_err = 32'sh8000_0000;
        end else begin
            sat_err = 32'sh7fff_ffff;
        end
    end

    assign reach_new   = r_reached | (JOINTS'(1) << r_idx);
    assign heard_above = (r_heard >> r_idx) >> 1;

    // sequencer: next state, unit operands and results
    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_given     = r_given;
        n_now       = r_now;
        n_start     = r_start;
        n_idx       = r_idx;
        n_tmp       = r_tmp;
        n_gt        = r_gt;
        n_lt        = r_lt;
        n_st        = r_st;
        n_stl       = r_stl;
        n_out_valid = 1'b0;
        n_out       = r_out;
        we_pos      = 1'b0;
        we_goal     = 1'b0;
        we_reach    = 1'b0;
        we_move     = 1'b0;
        u_a         = '0;
        u_b         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_st  = ST_NONE;
                    n_stl = 1'b0;
                    n_idx = '0;
                    unique case (i_req.cmd)
                        CMD_TICK: begin
                            n_now = r_now + 32'd1;
                        end
                        CMD_GOAL: begin
                            n_active = 1'b1;
                            n_given  = 1'b1;
                            n_start  = r_now;
                            n_state  = r_active ? S_GOAL_CANCEL : S_GOAL_CMD;
                        end
                        CMD_CANCEL: begin
                            if (r_given) begin
                                n_state = S_STOP;
                            end
                        end
                        CMD_STATE: begin
                            // joints beyond the configured count are dropped
                            if ({1'b0, i_req.joint} < 4'(JOINTS)) begin
                                n_idx   = i_req.joint[IW-1:0];
                                n_state = S_SAVE;
                            end
                        end
                    endcase
                end
            end

            // new goal: report the previous one canceled
            S_GOAL_CANCEL: begin
                n_out_valid = 1'b1;
                n_out = make_out(KIND_STATUS, 3'd0, '0, '0, ST_CANCELED, 1'b0, 1'b0);
                n_state = S_GOAL_CMD;
            end

            // new goal: store targets and command each joint
            S_GOAL_CMD: begin
                we_goal     = 1'b1;
                n_out_valid = 1'b1;
                n_out = make_out(KIND_CMD, 3'(r_idx), tgt_sel, '0, ST_NONE, 1'b0,
                                 r_idx == LAST_IDX);
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // cancel: stop every heard joint at its last position
            S_STOP: begin
                if (r_heard[r_idx]) begin
                    n_out_valid = 1'b1;
                    n_out = make_out(KIND_CMD, 3'(r_idx), r_pos[r_idx], '0, ST_NONE, 1'b0,
                                     !r_active && (heard_above == '0));
                end
                if (r_idx == LAST_IDX) begin
                    n_state = r_active ? S_CANCEL_ST : S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_CANCEL_ST: begin
                n_out_valid = 1'b1;
                n_out = make_out(KIND_STATUS, 3'd0, '0, '0, ST_CANCELED, 1'b0, 1'b1);
                n_active = 1'b0;
                n_state  = S_IDLE;
            end

            // state update: store position, then error = position - target
            S_SAVE: begin
                we_pos = 1'b1;
                u_a    = {{2{r_req.position[31]}}, r_req.position};
                u_b    = {{2{r_tgt[r_idx][31]}}, r_tgt[r_idx]};
                n_tmp  = u_diff;
                n_state = r_active ? S_ERR_ABS : S_IDLE;
            end

            S_ERR_ABS: begin
                u_a     = r_tmp[33] ? '0 : r_tmp;
                u_b     = r_tmp[33] ? r_tmp : '0;
                n_tmp   = u_diff;
                n_state = S_ERR_CMP;
            end

            // compare |error| with the reach threshold
            S_ERR_CMP: begin
                u_a     = r_tmp;
                u_b     = {3'b000, r_thr};
                n_gt    = u_pos;
                n_lt    = u_neg;
                n_state = S_ELAPSED;
            end

            // ticks since goal start, wrapping
            S_ELAPSED: begin
                u_a     = {2'b00, r_now};
                u_b     = {2'b00, r_start};
                n_tmp   = {2'b00, u_diff[31:0]};
                n_state = S_GRACE;
            end

            // off-target updates inside the grace window are ignored
            S_GRACE: begin
                u_a = r_tmp;
                u_b = {2'b00, r_grace};
                if (r_gt && u_neg) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DECIDE;
                end
            end

            // reach check, else the stall check for a joint not yet reached
            S_DECIDE: begin
                n_idx = '0;
                if (!r_reached[r_idx] && r_lt) begin
                    we_reach = 1'b1;
                    if (&reach_new) begin
                        n_st     = ST_SUCCEEDED;
                        n_active = 1'b0;
                    end
                    n_state = S_FEEDBACK;
                end else if (!r_reached[r_idx]) begin
                    n_idx   = r_idx;
                    n_state = S_VEL_LOAD;
                end else begin
                    n_state = S_FEEDBACK;
                end
            end

            S_VEL_LOAD: begin
                u_a     = {{2{r_req.velocity[31]}}, r_req.velocity};
                n_tmp   = u_diff;
                n_state = S_VEL_ABS;
            end

            S_VEL_ABS: begin
                u_a     = r_tmp[33] ? '0 : r_tmp;
                u_b     = r_tmp[33] ? r_tmp : '0;
                n_tmp   = u_diff;
                n_state = S_VEL_CMP;
            end

            // a moving joint restarts its stall clock
            S_VEL_CMP: begin
                u_a = r_tmp;
                u_b = {3'b000, r_svel};
                if (u_pos) begin
                    we_move = 1'b1;
                    n_idx   = '0;
                    n_state = S_FEEDBACK;
                end else begin
                    n_state = S_MOVE_ELAP;
                end
            end

            S_MOVE_ELAP: begin
                u_a     = {2'b00, r_now};
                u_b     = {2'b00, r_mtime[r_idx]};
                n_tmp   = {2'b00, u_diff[31:0]};
                n_state = S_MOVE_CMP;
            end

            // still too long: abort as stalled
            S_MOVE_CMP: begin
                u_a   = r_tmp;
                u_b   = {2'b00, r_timeout};
                n_idx = '0;
                if (u_pos) begin
                    n_st     = ST_ABORTED;
                    n_stl    = 1'b1;
                    n_active = 1'b0;
                end
                n_state = S_FEEDBACK;
            end

            // one feedback entry per joint, error = target - position saturated
            S_FEEDBACK: begin
                u_a = {{2{r_tgt[r_idx][31]}}, r_tgt[r_idx]};
                u_b = {{2{r_pos[r_idx][31]}}, r_pos[r_idx]};
                n_out_valid = 1'b1;
                n_out = make_out(KIND_FB, 3'(r_idx), r_pos[r_idx], sat_err, ST_NONE,
                                 r_stl, (r_idx == LAST_IDX) && (r_st == ST_NONE));
                if (r_idx == LAST_IDX) begin
                    n_state = (r_st != ST_NONE) ? S_STATUS : S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_STATUS: begin
                n_out_valid = 1'b1;
                n_out = make_out(KIND_STATUS, 3'd0, '0, '0, r_st, r_stl, 1'b1);
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and goal registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_given     <= 1'b0;
            r_now       <= '0;
            r_start     <= '0;
            r_idx       <= '0;
            r_gt        <= 1'b0;
            r_lt        <= 1'b0;
            r_st        <= ST_NONE;
            r_stl       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_given     <= n_given;
            r_now       <= n_now;
            r_start     <= n_start;
            r_idx       <= n_idx;
            r_gt        <= n_gt;
            r_lt        <= n_lt;
            r_st        <= n_st;
            r_stl       <= n_stl;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THRESHOLD_RST;
            r_svel    <= STALL_VEL_RST;
            r_timeout <= TIMEOUT_RST;
            r_grace   <= GRACE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD: r_thr     <= i_cfg_data[30:0];
                CFG_STALL_VEL: r_svel    <= i_cfg_data[30:0];
                CFG_TIMEOUT:   r_timeout <= i_cfg_data;
                CFG_GRACE:     r_grace   <= i_cfg_data;
            endcase
        end
    end

    // per-joint stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heard   <= '0;
            r_reached <= '0;
            for (int k = 0; k < JOINTS; k++) begin
                r_tgt[k]   <= '0;
                r_pos[k]   <= '0;
                r_mtime[k] <= '0;
            end
        end else begin
            if (we_pos) begin
                r_pos[r_idx]   <= r_req.position;
                r_heard[r_idx] <= 1'b1;
            end
            if (we_goal) begin
                r_tgt[r_idx]     <= tgt_sel;
                r_mtime[r_idx]   <= r_now;
                r_reached[r_idx] <= 1'b0;
            end
            if (we_reach) begin
                r_reached[r_idx] <= 1'b1;
            end
            if (we_move) begin
                r_mtime[r_idx] <= r_now;
            end
        end
    end

    // request, unit result and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        r_tmp <= n_tmp;
        r_out <= n_out;
    end

    // the final result leaves as the sequencer returns to idle, or while a cancel
    // still walks joints that were never heard
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.last |-> !busy || (r_state == S_STOP))
        else $error("last result while sequencer still busy");

    // stalled flag on a status result only with the aborted status
    a_stall_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind == KIND_STATUS) |->
            (r_out.stalled == (r_out.status == ST_ABORTED)))
        else $error("stalled flag does not match status");

    // joint index stays inside the joint stores
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (32'(r_idx) < JOINTS))
        else $error("joint index out of range");

    // a goal request always starts a command sequence
    a_goal_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req.cmd == CMD_GOAL) |=> busy && r_active && r_given)
        else $error("goal request not taken up");

    // a success status only follows once every joint is reached
    a_success_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind == KIND_STATUS) && (r_out.status == ST_SUCCEEDED)
            |-> (&r_reached) && !r_active)
        else $error("success reported with unreached joints");

endmodule
